// ----- rtl/mlt_pkg.sv -----
// Shared types and constants of the MAC learning table.
package mlt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int CMD_W  = 2;
    localparam int MAC_W  = 48;
    localparam int PORT_W = 8;
    localparam int TAG_W  = 16;
    localparam int VLAN_W = 16;
    localparam int AGE_W  = 8;
    localparam int IDX_W  = 6;

    localparam logic [MAC_W-1:0]  BCAST_MAC = '1;
    localparam logic [TAG_W-1:0]  VLAN_TPID = 16'h8100;
    localparam logic [AGE_W-1:0]  AGE_FRESH = 8'hFF;
    localparam logic [AGE_W-1:0]  AGE_LAST  = 8'h01;
    localparam logic [PORT_W-1:0] PORT_NONE = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_LEARN  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [AGE_W-1:0]  age;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [VLAN_W-1:0] vlan;
    } t_entry;

endpackage

// ----- rtl/mlt_if.sv -----
// Request and response channel interfaces of the MAC learning table.
interface mlt_req_if import mlt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [MAC_W-1:0]  mac_addr;
    logic [PORT_W-1:0] src_port;
    logic [TAG_W-1:0]  tag_type;
    logic [TAG_W-1:0]  tag_control;

    modport source (output valid, cmd, mac_addr, src_port, tag_type, tag_control,
                    input ready);
    modport sink (input valid, cmd, mac_addr, src_port, tag_type, tag_control,
                  output ready);
endinterface

interface mlt_rsp_if import mlt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [PORT_W-1:0] found_port;
    logic [VLAN_W-1:0] found_vlan;
    logic [IDX_W-1:0]  entry_index;

    modport source (output valid, hit, found_port, found_vlan, entry_index,
                    input ready);
    modport sink (input valid, hit, found_port, found_vlan, entry_index,
                  output ready);
endinterface

// ----- rtl/mlt_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module mlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mac_learning_table_with_aging.sv -----
// Top level of the MAC source-address learning table with per-entry aging.
//
// Every command but a learn of the broadcast address scans the whole table in
// memory, one entry per cycle. A learn adds a write of the chosen entry after
// its scan, and a learn of the broadcast address skips the scan and the write.
// The table memory delivers one entry per cycle on its read port. A finished
// result waits in an output register, and the next request is taken while it
// waits. After reset a clearing pass empties the table before the first request
// transfer.
module mac_learning_table_with_aging import mlt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlt_req_if.sink    i_req,
    mlt_rsp_if.source  o_rsp
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = AW + 1;
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_pv;
    logic [AW-1:0]     r_pidx;
    t_cmd              r_cmd;
    logic [MAC_W-1:0]  r_mac;
    logic [PORT_W-1:0] r_port;
    logic [VLAN_W-1:0] r_vlan;

    logic              r_match;
    logic [AW-1:0]     r_midx;
    logic [PORT_W-1:0] r_mport;
    logic [VLAN_W-1:0] r_mvlan;
    logic              r_free;
    logic [AW-1:0]     r_fidx;
    logic              r_oval;
    logic [AW-1:0]     r_oidx;
    logic [AGE_W-1:0]  r_oage;

    logic              r_out_valid;
    logic              r_hit;
    logic [PORT_W-1:0] r_fport;
    logic [VLAN_W-1:0] r_fvlan;
    logic [IDX_W-1:0]  r_eidx;

    logic              req_xfer;
    logic              load_out;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    t_entry            ram_wdata;
    t_entry            rd;
    logic              rd_live;
    logic [AGE_W-1:0]  aged;
    logic [AW-1:0]     chosen;
    logic              is_bcast;
    logic              res_hit;
    logic [PORT_W-1:0] res_port;
    logic [VLAN_W-1:0] res_vlan;
    logic [IDX_W-1:0]  res_idx;

    mlt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    assign req_xfer = i_req.valid && i_req.ready;
    assign is_bcast = (r_mac == BCAST_MAC);
    assign rd_live  = (rd.age != '0);
    assign chosen   = r_match ? r_midx : (r_free ? r_fidx : r_oidx);

    always_comb begin
        aged = '0;
        if (rd_live) begin
            aged = (r_cmd == CMD_CLEAR) ? AGE_LAST : rd.age - AGE_LAST;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_cnt == CNT_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (req_xfer) begin
                    if (t_cmd'(i_req.cmd) == CMD_LEARN && i_req.mac_addr == BCAST_MAC) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cnt == CNT_END && !r_pv) begin
                    n_state = (r_cmd == CMD_LEARN) ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: n_state = S_DONE;
            S_DONE: begin
                if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = 1'b0;
        load_out    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_pidx;
        ram_wdata   = rd;
        ram_raddr   = r_cnt[AW-1:0];
        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = '0;
            end
            S_IDLE: i_req.ready = 1'b1;
            S_SCAN: begin
                if (r_pv && (r_cmd == CMD_TICK || r_cmd == CMD_CLEAR)) begin
                    ram_we        = 1'b1;
                    ram_wdata.age = aged;
                end
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = chosen;
                ram_wdata = '{age: AGE_FRESH, mac: r_mac, port: r_port, vlan: r_vlan};
            end
            S_DONE: load_out = !r_out_valid || o_rsp.ready;
            default: ;
        endcase
    end

    always_comb begin
        res_hit  = 1'b0;
        res_port = PORT_NONE;
        res_vlan = '0;
        res_idx  = '0;
        if (r_cmd == CMD_LEARN && !is_bcast) begin
            res_hit  = r_match;
            res_port = r_port;
            res_vlan = r_vlan;
            res_idx  = IDX_W'(chosen);
        end else if (r_cmd == CMD_LOOKUP && r_match) begin
            res_hit  = 1'b1;
            res_port = r_mport;
            res_vlan = r_mvlan;
            res_idx  = IDX_W'(r_midx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_SCAN) && (r_cnt < CNT_END);
            if (r_state == S_INIT || (r_state == S_SCAN && r_cnt < CNT_END)) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (req_xfer) begin
                r_cnt <= '0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt[AW-1:0];
        if (req_xfer) begin
            r_cmd   <= t_cmd'(i_req.cmd);
            r_mac   <= i_req.mac_addr;
            r_port  <= i_req.src_port;
            r_vlan  <= (i_req.tag_type == VLAN_TPID) ? i_req.tag_control : '0;
            r_match <= 1'b0;
            r_free  <= 1'b0;
            r_oval  <= 1'b0;
        end else if (r_state == S_SCAN && r_pv) begin
            if (rd_live && rd.mac == r_mac && !r_match) begin
                r_match <= 1'b1;
                r_midx  <= r_pidx;
                r_mport <= rd.port;
                r_mvlan <= rd.vlan;
            end
            if (!rd_live && !r_free) begin
                r_free <= 1'b1;
                r_fidx <= r_pidx;
            end
            if (rd_live && (!r_oval || rd.age < r_oage)) begin
                r_oval <= 1'b1;
                r_oidx <= r_pidx;
                r_oage <= rd.age;
            end
        end
        if (load_out) begin
            r_hit   <= res_hit;
            r_fport <= res_port;
            r_fvlan <= res_vlan;
            r_eidx  <= res_idx;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_hit;
    assign o_rsp.found_port  = r_fport;
    assign o_rsp.found_vlan  = r_fvlan;
    assign o_rsp.entry_index = r_eidx;

endmodule

// ----- rtl/mlt_checker.sv -----
// Port-level assertions of the MAC learning table and their bind to the top level.
module mlt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready
);

    logic       req_xfer;
    logic       rsp_xfer;
    logic [2:0] r_pend;

    assign req_xfer = i_req_valid && i_req_ready;
    assign rsp_xfer = i_rsp_valid && i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 3'(req_xfer) - 3'(rsp_xfer);
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("Response valid dropped before its transfer.");

    a_no_extra_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_pend != 3'd0)
        else $error("Response offered with no request outstanding.");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd2)
        else $error("More than two requests outstanding.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer |=> !i_req_ready)
        else $error("Request taken while the previous one is still in work.");

endmodule

bind mac_learning_table_with_aging mlt_checker u_mlt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready)
);

// ----- test/mac_learning_table_with_aging_tb.sv -----
// Testbench for the MAC learning table: directed and random commands checked against a table model.
module mac_learning_table_with_aging_tb;
    import mlt_pkg::*;

    localparam int ENTRIES       = TABLE_ENTRIES_DEF;
    localparam int RANDOM_ITEMS  = 900;
    localparam int POOL_SIZE     = 96;
    localparam int SETTLE_CYCLES = ENTRIES + 16;

    typedef struct {
        t_cmd              cmd;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [TAG_W-1:0]  tag_type;
        logic [TAG_W-1:0]  tag_control;
        bit                drain;
    } t_request;

    typedef struct packed {
        logic              hit;
        logic [PORT_W-1:0] port;
        logic [VLAN_W-1:0] vlan;
        logic [IDX_W-1:0]  index;
    } t_lookup_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mlt_req_if req_if();
    mlt_rsp_if rsp_if();

    mac_learning_table_with_aging u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic [AGE_W-1:0]  age_tbl  [ENTRIES];
    logic [MAC_W-1:0]  mac_tbl  [ENTRIES];
    logic [PORT_W-1:0] port_tbl [ENTRIES];
    logic [VLAN_W-1:0] vlan_tbl [ENTRIES];

    t_request       frame_q[$];
    t_lookup_result lookup_q[$];
    logic [MAC_W-1:0] mac_pool [POOL_SIZE];

    int       errors       = 0;
    int       total_frames = 0;
    int       frames_taken = 0;
    t_request cur_frame;
    bit       have_frame   = 1'b0;
    int       gap_left     = 0;
    bit       calm_tx      = 1'b0;
    int       stall_left   = 0;
    bit       calm_rx      = 1'b0;
    logic     req_xfer     = 1'b0;
    logic     rsp_xfer     = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    function automatic int find_live(logic [MAC_W-1:0] m);
        for (int i = 0; i < ENTRIES; i++) begin
            if (age_tbl[i] != '0 && mac_tbl[i] == m) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_lookup_result table_step(t_request r);
        t_lookup_result res;
        int             idx;
        logic [VLAN_W-1:0] vlan;
        res = '{hit: 1'b0, port: PORT_NONE, vlan: '0, index: '0};
        case (r.cmd)
            CMD_LEARN: begin
                if (r.mac != BCAST_MAC) begin
                    idx = find_live(r.mac);
                    res.hit = (idx >= 0);
                    if (idx < 0) begin
                        idx = 0;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (age_tbl[i] == '0) begin
                                idx = i;
                                break;
                            end
                            if (age_tbl[i] < age_tbl[idx]) begin
                                idx = i;
                            end
                        end
                    end
                    vlan = (r.tag_type == VLAN_TPID) ? r.tag_control : '0;
                    age_tbl[idx]  = AGE_FRESH;
                    mac_tbl[idx]  = r.mac;
                    port_tbl[idx] = r.port;
                    vlan_tbl[idx] = vlan;
                    res.port  = r.port;
                    res.vlan  = vlan;
                    res.index = IDX_W'(idx);
                end
            end
            CMD_LOOKUP: begin
                idx = find_live(r.mac);
                if (idx >= 0) begin
                    res.hit   = 1'b1;
                    res.port  = port_tbl[idx];
                    res.vlan  = vlan_tbl[idx];
                    res.index = IDX_W'(idx);
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (age_tbl[i] != '0) begin
                        age_tbl[i] = age_tbl[i] - 1'b1;
                    end
                end
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (age_tbl[i] != '0) begin
                        age_tbl[i] = AGE_LAST;
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic void push_frame(t_cmd c, logic [MAC_W-1:0] m, logic [PORT_W-1:0] p,
                                       logic [TAG_W-1:0] tt, logic [TAG_W-1:0] tc,
                                       bit drain = 1'b0);
        t_request r;
        r.cmd         = c;
        r.mac         = m;
        r.port        = p;
        r.tag_type    = tt;
        r.tag_control = tc;
        r.drain       = drain;
        frame_q.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        t_request       seen;
        t_lookup_result got;
        t_lookup_result want;
        req_xfer <= i_rst_n && req_if.valid && req_if.ready;
        rsp_xfer <= i_rst_n && rsp_if.valid && rsp_if.ready;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = '{hit: rsp_if.hit, port: rsp_if.found_port, vlan: rsp_if.found_vlan,
                    index: rsp_if.entry_index};
            if (lookup_q.size() == 0) begin
                report_mismatch("result with no request pending", 64'(got), '0);
            end else begin
                want = lookup_q.pop_front();
                if (got.hit !== want.hit) begin
                    report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                end
                if (got.port !== want.port) begin
                    report_mismatch("found_port", 64'(got.port), 64'(want.port));
                end
                if (got.vlan !== want.vlan) begin
                    report_mismatch("found_vlan", 64'(got.vlan), 64'(want.vlan));
                end
                if (got.index !== want.index) begin
                    report_mismatch("entry_index", 64'(got.index), 64'(want.index));
                end
            end
        end
        if (i_rst_n && req_if.valid && req_if.ready) begin
            seen.cmd         = t_cmd'(req_if.cmd);
            seen.mac         = req_if.mac_addr;
            seen.port        = req_if.src_port;
            seen.tag_type    = req_if.tag_type;
            seen.tag_control = req_if.tag_control;
            seen.drain       = 1'b0;
            lookup_q.push_back(table_step(seen));
            frames_taken++;
        end
    end

    always @(negedge i_clk) begin
        logic drive_valid;
        drive_valid = 1'b0;
        if (!i_rst_n) begin
            drive_valid = 1'b0;
        end else if (req_if.valid && !req_xfer) begin
            drive_valid = 1'b1;
        end else begin
            if (!have_frame && frame_q.size() != 0) begin
                cur_frame  = frame_q.pop_front();
                have_frame = 1'b1;
                if ($urandom_range(0, 31) == 0) begin
                    calm_tx = !calm_tx;
                end
                gap_left = calm_tx ? 0 : $urandom_range(0, 15);
            end
            if (have_frame) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (!(cur_frame.drain && lookup_q.size() != 0)) begin
                    drive_valid            = 1'b1;
                    req_if.cmd         <= cur_frame.cmd;
                    req_if.mac_addr    <= cur_frame.mac;
                    req_if.src_port    <= cur_frame.port;
                    req_if.tag_type    <= cur_frame.tag_type;
                    req_if.tag_control <= cur_frame.tag_control;
                    have_frame             = 1'b0;
                end
            end
        end
        req_if.valid <= drive_valid;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_xfer) begin
                if ($urandom_range(0, 31) == 0) begin
                    calm_rx = !calm_rx;
                end
                stall_left = calm_rx ? 0 : $urandom_range(0, 15);
            end
            if (stall_left == 0) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b0;
                if (rsp_if.valid) begin
                    stall_left--;
                end
            end
        end
    end

    initial begin
        int                pick;
        logic [MAC_W-1:0]  m;
        logic [TAG_W-1:0]  tt;

        req_if.valid       = 1'b0;
        req_if.cmd         = CMD_LEARN;
        req_if.mac_addr    = '0;
        req_if.src_port    = '0;
        req_if.tag_type    = '0;
        req_if.tag_control = '0;
        rsp_if.ready       = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            age_tbl[i]  = '0;
            mac_tbl[i]  = '0;
            port_tbl[i] = '0;
            vlan_tbl[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            mac_pool[i] = MAC_W'({$urandom, $urandom});
        end

        push_frame(CMD_LOOKUP, 48'h0, 8'h00, 16'h0000, 16'h0000);
        push_frame(CMD_LEARN, 48'h0, 8'h00, 16'h0000, 16'hFFFF);
        push_frame(CMD_LEARN, 48'hFFFF_FFFF_FFFE, 8'hFF, VLAN_TPID, 16'hFFFF);
        push_frame(CMD_LEARN, BCAST_MAC, 8'h07, VLAN_TPID, 16'h1234);
        push_frame(CMD_LOOKUP, BCAST_MAC, 8'h00, 16'h0000, 16'h0000);
        push_frame(CMD_LOOKUP, 48'h0, 8'hFF, 16'hFFFF, 16'hFFFF);
        push_frame(CMD_LOOKUP, 48'hFFFF_FFFF_FFFE, 8'h00, 16'h0000, 16'h0000);
        push_frame(CMD_LEARN, 48'h0, 8'h5A, VLAN_TPID, 16'h0000);
        push_frame(CMD_LEARN, 48'h1, 8'h01, 16'h8101, 16'hABCD);
        push_frame(CMD_LEARN, 48'h2, 8'h02, 16'h0081, 16'hFFFF);
        push_frame(CMD_LEARN, 48'h3, 8'h03, 16'hFFFF, 16'h5555);
        push_frame(CMD_TICK, 48'h0, 8'h00, 16'h0000, 16'h0000);
        push_frame(CMD_LOOKUP, 48'h1, 8'h00, 16'h0000, 16'h0000);
        push_frame(CMD_CLEAR, 48'hFFFF_FFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        push_frame(CMD_LOOKUP, 48'h2, 8'h00, 16'h0000, 16'h0000);
        push_frame(CMD_LEARN, 48'h4, 8'h44, VLAN_TPID, 16'h0444, 1'b1);
        push_frame(CMD_TICK, 48'h0, 8'h00, 16'h0000, 16'h0000);
        push_frame(CMD_LOOKUP, 48'h0, 8'h00, 16'h0000, 16'h0000);
        push_frame(CMD_LOOKUP, 48'h4, 8'h00, 16'h0000, 16'h0000);
        push_frame(CMD_LEARN, 48'hAAAA_AAAA_AAAA, 8'hAA, VLAN_TPID, 16'hAAAA);
        push_frame(CMD_LEARN, 48'h5555_5555_5555, 8'h55, VLAN_TPID, 16'h0F0F);
        push_frame(CMD_CLEAR, 48'h0, 8'h00, 16'h0000, 16'h0000);
        push_frame(CMD_TICK, 48'h0, 8'h00, 16'h0000, 16'h0000);
        push_frame(CMD_TICK, 48'h0, 8'h00, 16'h0000, 16'h0000);

        // Most traffic reuses a pool larger than the table, so it fills and
        // the oldest entry gets replaced; the rest is random addresses and the broadcast address.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 199);
            tt   = ($urandom_range(0, 2) != 0) ? VLAN_TPID : TAG_W'($urandom);
            m    = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick < 100) begin
                push_frame(CMD_LEARN, m, PORT_W'($urandom), tt, TAG_W'($urandom),
                           (n % 200) == 199);
            end else if (pick < 160) begin
                push_frame(CMD_LOOKUP, m, PORT_W'($urandom), tt, TAG_W'($urandom));
            end else if (pick < 186) begin
                push_frame(CMD_TICK, m, PORT_W'($urandom), tt, TAG_W'($urandom));
            end else if (pick < 187) begin
                push_frame(CMD_CLEAR, m, PORT_W'($urandom), tt, TAG_W'($urandom));
            end else if (pick < 197) begin
                m = MAC_W'({$urandom, $urandom});
                push_frame((pick < 193) ? CMD_LEARN : CMD_LOOKUP, m, PORT_W'($urandom),
                           TAG_W'($urandom), TAG_W'($urandom));
            end else begin
                push_frame($urandom_range(0, 1) ? CMD_LEARN : CMD_LOOKUP, BCAST_MAC,
                           PORT_W'($urandom), tt, TAG_W'($urandom));
            end
        end
        total_frames = frame_q.size();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (frames_taken < total_frames || lookup_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
